/* hw/rtl/csq_pkg.sv */
`timescale 1ns / 1ps
// Shared types, operation codes and default sizes of the counting semaphore unit.
package csq_pkg;

	localparam int NUM_SEMS_DEF   = 128;
	localparam int NUM_PROCS_DEF  = 64;
	localparam int COUNT_BITS_DEF = 16;

	localparam int TYPE_W    = 3;
	localparam int SEM_IDX_W = 7;
	localparam int COUNT_W   = 16;
	localparam int PROC_ID_W = 6;

	typedef enum logic [TYPE_W-1:0] {
		OP_CREATE  = 3'd0,
		OP_WAIT    = 3'd1,
		OP_TRYWAIT = 3'd2,
		OP_SIGNAL  = 3'd3,
		OP_DESTROY = 3'd4
	} req_op_t;

	typedef struct packed {
		logic [TYPE_W-1:0]           req_type;
		logic [SEM_IDX_W-1:0]        sem_index;
		logic signed [COUNT_W-1:0]   start_count;
		logic [PROC_ID_W-1:0]        caller_proc;
	} req_t;

	typedef struct packed {
		logic                        create_ok;
		logic [SEM_IDX_W-1:0]        new_sem_index;
		logic                        acquired;
		logic                        caller_blocked;
		logic                        woken_valid;
		logic [PROC_ID_W-1:0]        woken_proc;
		logic signed [COUNT_W-1:0]   count_after;
	} rsp_t;

endpackage

/* hw/rtl/csq_stream_if.sv */
`timescale 1ns / 1ps
// Valid/ready stream interface that carries one beat of a payload type.
interface csq_stream_if #(parameter type T = logic);

	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

/* hw/rtl/csq_ram.sv */
`timescale 1ns / 1ps
// Simple dual-port RAM with one write port and one registered read port.
module csq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/counting_semaphore_wait_queues_unit.sv */
`timescale 1ns / 1ps
// Top level of the counting semaphore table with FIFO wait queues.
//
// Requests arrive as beats on the req channel (create, wait, trywait, signal,
// destroy) and every request produces exactly one beat on the rsp channel, in
// request order. A create claims the lowest free slot; wait and signal report
// which process must block or may run again, and every response to a known
// request carries the count of the addressed semaphore after the request.
// A request passes an input stage (semaphore record read), a second stage
// (next-waiter link read and record write-back) and the output register.
// One request is taken per cycle while req.ready is high; back-to-back
// requests on the same semaphore are served by forwarding the pending record
// and link writes, and the count update, the queue update and the free-slot
// priority encoder all sit in one stage.
// Reset clears the use bits, the record valid bits and the pipeline; a record
// whose valid bit is clear reads as zero, so no clearing pass is needed and
// requests are accepted right after reset. When the receiver holds ready low
// the output register keeps its beat and the earlier stages fill up before
// req.ready drops.
module counting_semaphore_wait_queues_unit #(
	parameter int NUM_SEMS   = csq_pkg::NUM_SEMS_DEF,
	parameter int NUM_PROCS  = csq_pkg::NUM_PROCS_DEF,
	parameter int COUNT_BITS = csq_pkg::COUNT_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	csq_stream_if.sink   req,
	csq_stream_if.source rsp
);

	import csq_pkg::*;

	localparam int SEM_W      = $clog2(NUM_SEMS);
	localparam int PROC_W     = $clog2(NUM_PROCS);
	localparam int CALLER_IDS = 2 ** PROC_ID_W;
	localparam int EXT_W      = ((COUNT_BITS > COUNT_W) ? COUNT_BITS : COUNT_W) + 1;

	localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
	localparam logic signed [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
	localparam logic signed [EXT_W-1:0] CNT_MAX_EXT = EXT_W'(CNT_MAX);
	localparam logic signed [EXT_W-1:0] CNT_MIN_EXT = EXT_W'(CNT_MIN);

	typedef struct packed {
		logic                         nonempty;
		logic [PROC_W-1:0]            head;
		logic [PROC_W-1:0]            tail;
		logic signed [COUNT_BITS-1:0] count;
	} sem_rec_t;

	localparam int REC_W = $bits(sem_rec_t);

	typedef logic [CALLER_IDS-1:0][PROC_W-1:0] caller_tab_t;

	function automatic caller_tab_t build_caller_tab();
		caller_tab_t tab;
		for (int i = 0; i < CALLER_IDS; i++) begin
			tab[i] = PROC_W'(i % NUM_PROCS);
		end
		return tab;
	endfunction

	localparam caller_tab_t CALLER_TAB = build_caller_tab();

	// Stage control.
	logic s1_v_q, s2_v_q, out_v_q;
	logic out_en, s2_en, s1_en, in_fire, s1_adv, s2_adv;

	assign out_en    = !out_v_q || rsp.ready;
	assign s2_en     = !s2_v_q || out_en;
	assign s1_en     = !s1_v_q || s2_en;
	assign req.ready = s1_en;
	assign in_fire   = req.valid && s1_en;
	assign s1_adv    = s1_v_q && s2_en;
	assign s2_adv    = s2_v_q && out_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s1_en) begin
				s1_v_q <= req.valid;
			end
			if (s2_en) begin
				s2_v_q <= s1_v_q;
			end
			if (out_en) begin
				out_v_q <= s2_v_q;
			end
		end
	end

	// The caller id is reduced modulo the process count through a constant table.
	logic [PROC_W-1:0] caller_in;

	assign caller_in = CALLER_TAB[req.data.caller_proc];

	// Input stage registers.
	logic [TYPE_W-1:0]         op_s1;
	logic [SEM_IDX_W-1:0]      sem_idx_s1;
	logic signed [COUNT_W-1:0] init_s1;
	logic [PROC_W-1:0]         caller_s1;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1      <= req.data.req_type;
			sem_idx_s1 <= req.data.sem_index;
			init_s1    <= req.data.start_count;
			caller_s1  <= caller_in;
		end
	end

	logic [SEM_W-1:0] sem_addr_s1;
	logic             sem_ok_s1;

	assign sem_addr_s1 = SEM_W'(sem_idx_s1);
	assign sem_ok_s1   = (int'(sem_idx_s1) < NUM_SEMS);

	// Semaphore record memory, read as the request enters the input stage.
	logic             rec_we;
	logic [SEM_W-1:0] rec_raddr;
	logic [REC_W-1:0] rec_rd_raw;
	sem_rec_t         rec_rd;
	sem_rec_t         rec_s2_final;

	logic             rec_we_s2;
	logic [SEM_W-1:0] rec_waddr_s2;

	assign rec_raddr = s1_en ? SEM_W'(req.data.sem_index) : sem_addr_s1;
	assign rec_we    = s2_adv && rec_we_s2;
	assign rec_rd    = sem_rec_t'(rec_rd_raw);

	csq_ram #(
		.WIDTH(REC_W),
		.DEPTH(NUM_SEMS)
	) u_rec_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (rec_waddr_s2),
		.wdata (REC_W'(rec_s2_final)),
		.raddr (rec_raddr),
		.rdata (rec_rd_raw)
	);

	logic [NUM_SEMS-1:0] rec_valid_q;
	logic [NUM_SEMS-1:0] use_q;
	logic                lastrec_v_q;
	logic [SEM_W-1:0]    lastrec_addr_q;
	sem_rec_t            lastrec_q;

	// Current record of the addressed semaphore, newest write first.
	sem_rec_t rec_cur;

	always_comb begin
		if (s2_v_q && rec_we_s2 && rec_waddr_s2 == sem_addr_s1) begin
			rec_cur = rec_s2_final;
		end else if (lastrec_v_q && lastrec_addr_q == sem_addr_s1) begin
			rec_cur = lastrec_q;
		end else if (rec_valid_q[sem_addr_s1]) begin
			rec_cur = rec_rd;
		end else begin
			rec_cur = '0;
		end
	end

	// Lowest free slot for create.
	logic             free_found;
	logic [SEM_W-1:0] free_idx;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_SEMS - 1; i >= 0; i--) begin
			if (!use_q[i]) begin
				free_found = 1'b1;
				free_idx   = SEM_W'(i);
			end
		end
	end

	logic signed [EXT_W-1:0]      init_ext;
	logic signed [COUNT_BITS-1:0] init_cnt;

	always_comb begin
		init_ext = EXT_W'(init_s1);
		if (init_ext > CNT_MAX_EXT) begin
			init_cnt = CNT_MAX;
		end else if (init_ext < CNT_MIN_EXT) begin
			init_cnt = CNT_MIN;
		end else begin
			init_cnt = COUNT_BITS'(init_ext);
		end
	end

	// Request execution.
	sem_rec_t          rec_nxt;
	logic              rec_we_nxt;
	logic [SEM_W-1:0]  rec_waddr_nxt;
	logic              pop_adv_nxt;
	logic              nw_we_nxt;
	logic              use_we;
	logic              use_val;
	logic [SEM_W-1:0]  use_idx;
	rsp_t              rsp_nxt;

	always_comb begin
		rec_nxt       = rec_cur;
		rec_we_nxt    = 1'b0;
		rec_waddr_nxt = sem_addr_s1;
		pop_adv_nxt   = 1'b0;
		nw_we_nxt     = 1'b0;
		use_we        = 1'b0;
		use_val       = 1'b0;
		use_idx       = sem_addr_s1;
		rsp_nxt       = '0;
		case (op_s1)
			OP_CREATE: begin
				if (free_found) begin
					rec_nxt               = '0;
					rec_nxt.count         = init_cnt;
					rec_we_nxt            = 1'b1;
					rec_waddr_nxt         = free_idx;
					use_we                = 1'b1;
					use_val               = 1'b1;
					use_idx               = free_idx;
					rsp_nxt.create_ok     = 1'b1;
					rsp_nxt.new_sem_index = SEM_IDX_W'(free_idx);
					rsp_nxt.count_after   = COUNT_W'(init_cnt);
				end
			end
			OP_WAIT: begin
				if (sem_ok_s1) begin
					if (rec_cur.count != CNT_MIN) begin
						rec_nxt.count = rec_cur.count - COUNT_BITS'(1);
					end
					rec_we_nxt = 1'b1;
					if (rec_nxt.count[COUNT_BITS-1]) begin
						if (rec_cur.nonempty) begin
							nw_we_nxt = 1'b1;
						end else begin
							rec_nxt.head     = caller_s1;
							rec_nxt.nonempty = 1'b1;
						end
						rec_nxt.tail           = caller_s1;
						rsp_nxt.caller_blocked = 1'b1;
					end else begin
						rsp_nxt.acquired = 1'b1;
					end
					rsp_nxt.count_after = COUNT_W'(rec_nxt.count);
				end
			end
			OP_TRYWAIT: begin
				if (sem_ok_s1) begin
					if (!rec_cur.count[COUNT_BITS-1] && rec_cur.count != '0) begin
						rec_nxt.count    = rec_cur.count - COUNT_BITS'(1);
						rec_we_nxt       = 1'b1;
						rsp_nxt.acquired = 1'b1;
					end
					rsp_nxt.count_after = COUNT_W'(rec_nxt.count);
				end
			end
			OP_SIGNAL: begin
				if (sem_ok_s1) begin
					if (rec_cur.count != CNT_MAX) begin
						rec_nxt.count = rec_cur.count + COUNT_BITS'(1);
					end
					rec_we_nxt = 1'b1;
					if ((rec_nxt.count[COUNT_BITS-1] || rec_nxt.count == '0) &&
							rec_cur.nonempty) begin
						if (rec_cur.head == rec_cur.tail) begin
							rec_nxt.nonempty = 1'b0;
						end else begin
							pop_adv_nxt = 1'b1;
						end
						rsp_nxt.woken_valid = 1'b1;
						rsp_nxt.woken_proc  = PROC_ID_W'(rec_cur.head);
					end
					rsp_nxt.count_after = COUNT_W'(rec_nxt.count);
				end
			end
			OP_DESTROY: begin
				if (sem_ok_s1) begin
					use_we              = 1'b1;
					use_val             = 1'b0;
					rsp_nxt.count_after = COUNT_W'(rec_cur.count);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_q <= '0;
		end else if (s1_adv && use_we) begin
			use_q[use_idx] <= use_val;
		end
	end

	// Second stage registers.
	sem_rec_t          rec_s2;
	logic              pop_adv_s2;
	logic              nw_we_s2;
	logic [PROC_W-1:0] nw_waddr_s2;
	logic [PROC_W-1:0] nw_wdata_s2;
	logic [PROC_W-1:0] head_s2;
	rsp_t              rsp_s2;

	always_ff @(posedge clk) begin
		if (s2_en) begin
			rec_s2       <= rec_nxt;
			rec_we_s2    <= rec_we_nxt;
			rec_waddr_s2 <= rec_waddr_nxt;
			pop_adv_s2   <= pop_adv_nxt;
			nw_we_s2     <= nw_we_nxt;
			nw_waddr_s2  <= rec_cur.tail;
			nw_wdata_s2  <= caller_s1;
			head_s2      <= rec_cur.head;
			rsp_s2       <= rsp_nxt;
		end
	end

	// Next-waiter links, read at the popped head as the request enters stage two.
	logic              nw_we;
	logic [PROC_W-1:0] nw_raddr;
	logic [PROC_W-1:0] nw_rd;
	logic [PROC_W-1:0] nw_fwd;
	logic              lastnw_v_q;
	logic [PROC_W-1:0] lastnw_addr_q;
	logic [PROC_W-1:0] lastnw_q;

	assign nw_we    = s2_adv && nw_we_s2;
	assign nw_raddr = s2_en ? rec_cur.head : head_s2;

	csq_ram #(
		.WIDTH(PROC_W),
		.DEPTH(NUM_PROCS)
	) u_link_ram (
		.clk   (clk),
		.we    (nw_we),
		.waddr (nw_waddr_s2),
		.wdata (nw_wdata_s2),
		.raddr (nw_raddr),
		.rdata (nw_rd)
	);

	assign nw_fwd = (lastnw_v_q && lastnw_addr_q == head_s2) ? lastnw_q : nw_rd;

	always_comb begin
		rec_s2_final = rec_s2;
		if (pop_adv_s2) begin
			rec_s2_final.head = nw_fwd;
		end
	end

	// Write-back bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= '0;
			lastrec_v_q <= 1'b0;
			lastnw_v_q  <= 1'b0;
		end else begin
			if (rec_we) begin
				rec_valid_q[rec_waddr_s2] <= 1'b1;
				lastrec_v_q               <= 1'b1;
			end
			if (nw_we) begin
				lastnw_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rec_we) begin
			lastrec_addr_q <= rec_waddr_s2;
			lastrec_q      <= rec_s2_final;
		end
		if (nw_we) begin
			lastnw_addr_q <= nw_waddr_s2;
			lastnw_q      <= nw_wdata_s2;
		end
	end

	// Output register.
	rsp_t rsp_q;

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			rsp_q <= rsp_s2;
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.data  = rsp_q;

	// A slot claimed by a create stays marked in use until that create writes back.
	a_create_slot_used: assert property (@(posedge clk) disable iff (!arst_n)
		s2_v_q && rsp_s2.create_ok |-> use_q[rec_waddr_s2])
		else $error("slot claimed by create is not marked in use");

	// A head advance through the link table only happens for a signal that wakes a waiter.
	a_pop_wakes: assert property (@(posedge clk) disable iff (!arst_n)
		s2_v_q && pop_adv_s2 |-> rsp_s2.woken_valid && rsp_s2.count_after != '0 ||
			s2_v_q && pop_adv_s2 && rsp_s2.woken_valid)
		else $error("queue head advanced without a woken process");

	// A response beat that reports a wake reports no other outcome.
	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.woken_valid |->
			!rsp.data.caller_blocked && !rsp.data.acquired && !rsp.data.create_ok)
		else $error("wake reported together with another outcome");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the counting semaphore unit with directed and random request beats.
module tb;

	import csq_pkg::*;

	localparam int COUNT_MAX   = 2 ** (COUNT_W - 1) - 1;
	localparam int COUNT_MIN   = -COUNT_MAX - 1;
	localparam int IDLE_PCT    = 31;
	localparam int RANDOM_ITEMS = 1530;
	localparam int PAUSE_AT    = 500;
	localparam int CALM_FROM   = 700;
	localparam int CALM_TO     = 1000;
	localparam int TAIL_CYCLES = 20;
	localparam longint LIMIT_NS = 5_000_000;

	localparam logic [TYPE_W-1:0] OP_RSVD_FIRST = 3'd5;
	localparam logic [TYPE_W-1:0] OP_RSVD_LAST  = 3'd7;

	typedef enum int {MIX_QUEUES, MIX_FILL, MIX_FREE, MIX_NOISE} mix_t;

	typedef struct {
		req_t beat;
		bit   typed;
		rsp_t want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	bit   calm;
	int   mismatches;

	csq_stream_if #(.T(req_t)) req_if ();
	csq_stream_if #(.T(rsp_t)) rsp_if ();

	counting_semaphore_wait_queues_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	bit                        sem_busy    [NUM_SEMS_DEF];
	bit signed [COUNT_W-1:0]   sem_level   [NUM_SEMS_DEF];
	bit                        wq_nonempty [NUM_SEMS_DEF];
	bit [PROC_ID_W-1:0]        wq_head     [NUM_SEMS_DEF];
	bit [PROC_ID_W-1:0]        wq_tail     [NUM_SEMS_DEF];
	bit [PROC_ID_W-1:0]        proc_link   [NUM_PROCS_DEF];
	bit                        link_seen   [NUM_PROCS_DEF];

	rsp_t owed_replies [$];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic req_t rq(input logic [TYPE_W-1:0] op, input int idx, input int init,
			input int caller);
		req_t r;
		r.req_type    = op;
		r.sem_index   = SEM_IDX_W'(idx);
		r.start_count = COUNT_W'(init);
		r.caller_proc = PROC_ID_W'(caller);
		return r;
	endfunction

	function automatic rsp_t rs(input bit ok, input int idx, input bit acq, input bit blk,
			input bit wv, input int wp, input int cnt);
		rsp_t o;
		o.create_ok      = ok;
		o.new_sem_index  = SEM_IDX_W'(idx);
		o.acquired       = acq;
		o.caller_blocked = blk;
		o.woken_valid    = wv;
		o.woken_proc     = PROC_ID_W'(wp);
		o.count_after    = COUNT_W'(cnt);
		return o;
	endfunction

	function automatic rsp_t advance_semaphores(input req_t r);
		rsp_t               o;
		int                 lvl;
		int                 s;
		bit [PROC_ID_W-1:0] h;
		o = '0;
		s = int'(r.sem_index);
		if (r.req_type == OP_CREATE) begin
			for (int i = 0; i < NUM_SEMS_DEF; i++) begin
				if (!o.create_ok && !sem_busy[i]) begin
					sem_busy[i]    = 1'b1;
					sem_level[i]   = r.start_count;
					wq_nonempty[i] = 1'b0;
					wq_head[i]     = '0;
					wq_tail[i]     = '0;
					o.create_ok     = 1'b1;
					o.new_sem_index = SEM_IDX_W'(i);
					o.count_after   = r.start_count;
				end
			end
			return o;
		end
		if (r.req_type > OP_DESTROY)
			return o;
		case (r.req_type)
			OP_WAIT: begin
				lvl = sem_level[s] - 1;
				if (lvl < COUNT_MIN)
					lvl = COUNT_MIN;
				sem_level[s] = COUNT_W'(lvl);
				if (lvl < 0) begin
					if (wq_nonempty[s]) begin
						proc_link[wq_tail[s]] = r.caller_proc;
						link_seen[wq_tail[s]] = 1'b1;
					end else begin
						wq_head[s]     = r.caller_proc;
						wq_nonempty[s] = 1'b1;
					end
					wq_tail[s]       = r.caller_proc;
					o.caller_blocked = 1'b1;
				end else begin
					o.acquired = 1'b1;
				end
			end
			OP_TRYWAIT: begin
				if (sem_level[s] > 0) begin
					sem_level[s] = sem_level[s] - 1;
					o.acquired   = 1'b1;
				end
			end
			OP_SIGNAL: begin
				lvl = sem_level[s] + 1;
				if (lvl > COUNT_MAX)
					lvl = COUNT_MAX;
				sem_level[s] = COUNT_W'(lvl);
				if (lvl <= 0 && wq_nonempty[s]) begin
					h = wq_head[s];
					if (h == wq_tail[s])
						wq_nonempty[s] = 1'b0;
					else
						wq_head[s] = proc_link[h];
					o.woken_valid = 1'b1;
					o.woken_proc  = h;
				end
			end
			default: begin
				sem_busy[s] = 1'b0;
			end
		endcase
		o.count_after = sem_level[s];
		return o;
	endfunction

	// A signal that pops a waiter whose successor link was never written has no defined answer.
	function automatic bit reads_unset_link(input req_t r);
		int s;
		s = int'(r.sem_index);
		return r.req_type == OP_SIGNAL && wq_nonempty[s] && sem_level[s] + 1 <= 0 &&
			wq_head[s] != wq_tail[s] && !link_seen[wq_head[s]];
	endfunction

	function automatic req_t pick_request(input mix_t mix);
		req_t r;
		int   roll;
		roll = $urandom_range(99);
		r.caller_proc = PROC_ID_W'(($urandom_range(9) < 8) ? $urandom_range(11)
			: $urandom_range(63));
		r.sem_index   = SEM_IDX_W'(($urandom_range(9) < 8 && mix != MIX_FREE)
			? $urandom_range(7) : $urandom_range(127));
		case ($urandom_range(9))
			0: r.start_count = COUNT_W'(COUNT_MAX - int'($urandom_range(2)));
			1: r.start_count = COUNT_W'(COUNT_MIN + int'($urandom_range(2)));
			2: r.start_count = COUNT_W'($urandom());
			default: r.start_count = COUNT_W'(int'($urandom_range(6)) - 3);
		endcase
		case (mix)
			MIX_QUEUES: begin
				if (roll < 8)
					r.req_type = OP_CREATE;
				else if (roll < 38)
					r.req_type = OP_WAIT;
				else if (roll < 50)
					r.req_type = OP_TRYWAIT;
				else if (roll < 85)
					r.req_type = OP_SIGNAL;
				else if (roll < 95)
					r.req_type = OP_DESTROY;
				else
					r.req_type = TYPE_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
			end
			MIX_FILL: begin
				if ($urandom_range(1))
					r.sem_index = SEM_IDX_W'($urandom_range(127));
				if (roll < 65)
					r.req_type = OP_CREATE;
				else if (roll < 75)
					r.req_type = OP_WAIT;
				else if (roll < 85)
					r.req_type = OP_SIGNAL;
				else if (roll < 95)
					r.req_type = OP_TRYWAIT;
				else
					r.req_type = OP_DESTROY;
			end
			MIX_FREE: begin
				if (roll < 55)
					r.req_type = OP_DESTROY;
				else if (roll < 70)
					r.req_type = OP_WAIT;
				else if (roll < 85)
					r.req_type = OP_SIGNAL;
				else
					r.req_type = OP_CREATE;
			end
			default: begin
				r.req_type    = TYPE_W'($urandom_range(OP_RSVD_LAST));
				r.sem_index   = SEM_IDX_W'($urandom_range(127));
				r.start_count = COUNT_W'($urandom());
				r.caller_proc = PROC_ID_W'($urandom_range(63));
			end
		endcase
		if (reads_unset_link(r))
			r.req_type = OP_TRYWAIT;
		return r;
	endfunction

	task automatic offer_request(input req_t beat, input bit has_want, input rsp_t want);
		rsp_t outcome;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data  <= beat;
		do @(posedge clk); while (!req_if.ready);
		outcome = advance_semaphores(beat);
		owed_replies.push_back(has_want ? want : outcome);
	endtask

	task automatic await_replies();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (owed_replies.size() != 0)
			@(posedge clk);
	endtask

	function automatic void compare_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	initial begin
		plan_row_t plan [$];
		req_t      beat;
		mix_t      mix;
		arst_n       <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.data  <= '0;
		plan.push_back('{rq(OP_SIGNAL, 5, 0, 0), 1'b1, rs(0, 0, 0, 0, 0, 0, 1)});
		plan.push_back('{rq(OP_CREATE, 0, COUNT_MAX, 0), 1'b1, rs(1, 0, 0, 0, 0, 0, COUNT_MAX)});
		plan.push_back('{rq(OP_SIGNAL, 0, 0, 0), 1'b1, rs(0, 0, 0, 0, 0, 0, COUNT_MAX)});
		plan.push_back('{rq(OP_TRYWAIT, 0, 0, 0), 1'b1, rs(0, 0, 1, 0, 0, 0, COUNT_MAX - 1)});
		plan.push_back('{rq(OP_CREATE, 0, COUNT_MIN, 0), 1'b1, rs(1, 1, 0, 0, 0, 0, COUNT_MIN)});
		plan.push_back('{rq(OP_WAIT, 1, 0, 63), 1'b1, rs(0, 0, 0, 1, 0, 0, COUNT_MIN)});
		plan.push_back('{rq(OP_WAIT, 1, 0, 42), 1'b0, '0});
		plan.push_back('{rq(OP_TRYWAIT, 1, 0, 0), 1'b1, rs(0, 0, 0, 0, 0, 0, COUNT_MIN)});
		plan.push_back('{rq(OP_SIGNAL, 1, 0, 0), 1'b1, rs(0, 0, 0, 0, 1, 63, COUNT_MIN + 1)});
		plan.push_back('{rq(OP_SIGNAL, 1, 0, 0), 1'b1, rs(0, 0, 0, 0, 1, 42, COUNT_MIN + 2)});
		plan.push_back('{rq(OP_SIGNAL, 1, 0, 0), 1'b1, rs(0, 0, 0, 0, 0, 0, COUNT_MIN + 3)});
		plan.push_back('{rq(OP_CREATE, 0, 0, 0), 1'b1, rs(1, 2, 0, 0, 0, 0, 0)});
		plan.push_back('{rq(OP_WAIT, 2, 0, 21), 1'b0, '0});
		plan.push_back('{rq(OP_SIGNAL, 2, 0, 0), 1'b0, '0});
		plan.push_back('{rq(OP_DESTROY, 0, 0, 0), 1'b1, rs(0, 0, 0, 0, 0, 0, COUNT_MAX - 1)});
		plan.push_back('{rq(OP_CREATE, 0, 5, 7), 1'b1, rs(1, 0, 0, 0, 0, 0, 5)});
		plan.push_back('{rq(OP_DESTROY, 127, 0, 0), 1'b1, rs(0, 0, 0, 0, 0, 0, 0)});
		plan.push_back('{rq(OP_WAIT, 127, 0, 1), 1'b1, rs(0, 0, 0, 1, 0, 0, -1)});
		plan.push_back('{rq(OP_RSVD_FIRST, 127, 0, 0), 1'b1, '0});
		plan.push_back('{rq(OP_RSVD_LAST, 85, -1, 63), 1'b1, '0});
		plan.push_back('{rq(OP_TRYWAIT, 2, 0, 0), 1'b0, '0});
		plan.push_back('{rq(OP_WAIT, 0, 0, 0), 1'b0, '0});
		plan.push_back('{rq(OP_SIGNAL, 127, 0, 0), 1'b1, rs(0, 0, 0, 0, 1, 1, 0)});
		plan.push_back('{rq(OP_CREATE, 127, -1, 63), 1'b1, rs(1, 3, 0, 0, 0, 0, -1)});
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (plan[i])
			offer_request(plan[i].beat, plan[i].typed, plan[i].want);
		await_replies();
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == PAUSE_AT)
				await_replies();
			calm <= (n >= CALM_FROM && n < CALM_TO);
			case (n / 100)
				2, 3, 4, 10: mix = MIX_FILL;
				6, 12: mix = MIX_FREE;
				8, 14: mix = MIX_NOISE;
				default: mix = MIX_QUEUES;
			endcase
			beat = pick_request(mix);
			offer_request(beat, 1'b0, '0);
		end
		await_replies();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		rsp_t want;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_if.valid && rsp_if.ready) begin
				if (owed_replies.size() == 0) begin
					$display("%0t: response beat mismatch, expected none, got %p", $time,
						rsp_if.data);
					mismatches++;
				end else begin
					want = owed_replies.pop_front();
					compare_field("create_ok", 32'(want.create_ok),
						32'(rsp_if.data.create_ok));
					compare_field("new_sem_index", 32'(want.new_sem_index),
						32'(rsp_if.data.new_sem_index));
					compare_field("acquired", 32'(want.acquired),
						32'(rsp_if.data.acquired));
					compare_field("caller_blocked", 32'(want.caller_blocked),
						32'(rsp_if.data.caller_blocked));
					compare_field("woken_valid", 32'(want.woken_valid),
						32'(rsp_if.data.woken_valid));
					compare_field("woken_proc", 32'(want.woken_proc),
						32'(rsp_if.data.woken_proc));
					compare_field("count_after", 32'(want.count_after),
						32'(rsp_if.data.count_after));
				end
			end
			rsp_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin
		#(LIMIT_NS);
		$display("FAILURE");
		$finish;
	end

endmodule
